>>> rtl/hpen_pkg.sv
// Shared types, constants and compare helpers for the half-precision norm block.
// Used by hpen_fpu and half_precision_euclidean_norm; no dependencies.
package hpen_pkg;

   typedef enum logic [1:0] {FOP_MUL, FOP_ADD, FOP_DIV, FOP_SQRT} fop_type;

   localparam logic [2:0] RM_RNE = 3'd0;
   localparam logic [2:0] RM_RTZ = 3'd1;
   localparam logic [2:0] RM_RDN = 3'd2;
   localparam logic [2:0] RM_RUP = 3'd3;
   localparam logic [2:0] RM_RNA = 3'd4;

   localparam logic [15:0] H_ZERO    = 16'h0000;
   localparam logic [15:0] H_ONE     = 16'h3C00;
   localparam logic [15:0] H_QNAN    = 16'h7E00;
   localparam logic [15:0] H_INF     = 16'h7C00;
   localparam logic [15:0] T_SMALL   = 16'h2000;
   localparam logic [15:0] T_BIG     = 16'h4800;
   localparam logic [15:0] S_SMALL   = 16'h6C00;
   localparam logic [15:0] S_BIG     = 16'h0800;
   localparam logic [15:0] SCL_BIG   = 16'h7000;
   localparam logic [15:0] SCL_SMALL = 16'h0C00;

   function automatic logic h_nan(input logic [15:0] x);
      return x[14:0] > H_INF[14:0];
   endfunction

   function automatic logic h_inf(input logic [15:0] x);
      return x[14:0] == H_INF[14:0];
   endfunction

   function automatic logic h_zero(input logic [15:0] x);
      return x[14:0] == 15'd0;
   endfunction

   function automatic logic h_gt(input logic [15:0] a, input logic [15:0] b);
      logic signed [15:0] ka;
      logic signed [15:0] kb;
      ka = a[15] ? -$signed({1'b0, a[14:0]}) : $signed({1'b0, a[14:0]});
      kb = b[15] ? -$signed({1'b0, b[14:0]}) : $signed({1'b0, b[14:0]});
      return !h_nan(a) && !h_nan(b) && (ka > kb);
   endfunction

endpackage

>>> rtl/half_precision_euclidean_norm.sv
// A medium element is squared and added to its sum; a big or small one is scaled
// first, and a small one is dropped once a big one is seen. The last element adds
// the combine sequence, longest when medium and small sums must be merged (three
// square roots and two divides on the shared unit). A new request is taken only
// once the prior one is done. Reset is synchronous: sums clear, mode is nearest-even.
module half_precision_euclidean_norm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_element,
   input  logic        req_is_last,
   input  logic        req_empty_vector,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_norm,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);
   import hpen_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_AMUL, S_ASQ, S_AADD, S_CBEGIN, S_BM1, S_BM2, S_BM3, S_AM, S_AS1,
      S_AS2, S_RAT, S_T1, S_T2, S_T3, S_T4, S_SQRT, S_FIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {CLS_BIG, CLS_SMALL, CLS_MED} cls_type;

   state_type   state_ff;
   cls_type     cls_ff;
   logic        issued_ff;
   logic        last_ff;
   logic [2:0]  mode_ff;
   logic [15:0] small_ff, medium_ff, big_ff;
   logic        nbs_ff;
   logic [15:0] t_ff, r_ff, am_ff, as_ff, sumsq_ff, scl_ff, res_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_norm_ff;

   logic        accept;
   logic [15:0] ax;
   logic        is_step;
   logic        fpu_start;
   fop_type     fpu_op;
   logic [15:0] fpu_a, fpu_b;
   logic        fpu_done;
   logic [15:0] fpu_res;
   logic        as_gt;
   logic [15:0] ymax, ymin;
   logic        med_live;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign ax        = {1'b0, req_element[14:0]};
   assign is_step   = !(state_ff == S_IDLE || state_ff == S_CBEGIN || state_ff == S_OUT);
   assign fpu_start = is_step && !issued_ff;
   assign as_gt     = h_gt(as_ff, am_ff);
   assign ymax      = as_gt ? as_ff : am_ff;
   assign ymin      = as_gt ? am_ff : as_ff;
   assign med_live  = h_gt(medium_ff, H_ZERO) || h_nan(medium_ff);

   always_comb begin
      fpu_op = FOP_MUL;
      fpu_a  = t_ff;
      fpu_b  = t_ff;
      case (state_ff)
         S_AMUL: fpu_b = (cls_ff == CLS_BIG) ? S_BIG : S_SMALL;
         S_AADD: begin
            fpu_op = FOP_ADD;
            fpu_a  = (cls_ff == CLS_BIG) ? big_ff :
                     (cls_ff == CLS_SMALL) ? small_ff : medium_ff;
         end
         S_BM1: begin
            fpu_a = medium_ff;
            fpu_b = S_BIG;
         end
         S_BM2: fpu_b = S_BIG;
         S_BM3: begin
            fpu_op = FOP_ADD;
            fpu_a  = big_ff;
         end
         S_AM: begin
            fpu_op = FOP_SQRT;
            fpu_a  = medium_ff;
         end
         S_AS1: begin
            fpu_op = FOP_SQRT;
            fpu_a  = small_ff;
         end
         S_AS2: begin
            fpu_op = FOP_DIV;
            fpu_b  = S_SMALL;
         end
         S_RAT: begin
            fpu_op = FOP_DIV;
            fpu_a  = ymin;
            fpu_b  = ymax;
         end
         S_T1: begin
            fpu_a = ymax;
            fpu_b = ymax;
         end
         S_T2: begin
            fpu_a = r_ff;
            fpu_b = r_ff;
         end
         S_T3: begin
            fpu_op = FOP_ADD;
            fpu_a  = H_ONE;
            fpu_b  = r_ff;
         end
         S_T4: fpu_b = r_ff;
         S_SQRT: begin
            fpu_op = FOP_SQRT;
            fpu_a  = sumsq_ff;
         end
         S_FIN: fpu_a = scl_ff;
         default: fpu_op = FOP_MUL;
      endcase
   end

   hpen_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .start  (fpu_start),
      .op     (fpu_op),
      .opa    (fpu_a),
      .opb    (fpu_b),
      .mode   (mode_ff),
      .done   (fpu_done),
      .result (fpu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         mode_ff      <= RM_RNE;
         small_ff     <= H_ZERO;
         medium_ff    <= H_ZERO;
         big_ff       <= H_ZERO;
         nbs_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) mode_ff <= csr_wr_data;
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         if (is_step) begin
            if (!issued_ff) issued_ff <= 1'b1;
            else if (fpu_done) begin
               issued_ff <= 1'b0;
               case (state_ff)
                  S_AMUL: begin
                     t_ff     <= fpu_res;
                     state_ff <= S_ASQ;
                  end
                  S_ASQ: begin
                     t_ff     <= fpu_res;
                     state_ff <= S_AADD;
                  end
                  S_AADD: begin
                     case (cls_ff)
                        CLS_BIG: begin
                           big_ff <= fpu_res;
                           nbs_ff <= 1'b0;
                        end
                        CLS_SMALL: small_ff <= fpu_res;
                        default: medium_ff <= fpu_res;
                     endcase
                     state_ff <= last_ff ? S_CBEGIN : S_IDLE;
                  end
                  S_BM1: begin
                     t_ff     <= fpu_res;
                     state_ff <= S_BM2;
                  end
                  S_BM2: begin
                     t_ff     <= fpu_res;
                     state_ff <= S_BM3;
                  end
                  S_BM3: begin
                     sumsq_ff <= fpu_res;
                     scl_ff   <= SCL_BIG;
                     state_ff <= S_SQRT;
                  end
                  S_AM: begin
                     am_ff    <= fpu_res;
                     state_ff <= S_AS1;
                  end
                  S_AS1: begin
                     t_ff     <= fpu_res;
                     state_ff <= S_AS2;
                  end
                  S_AS2: begin
                     as_ff    <= fpu_res;
                     state_ff <= S_RAT;
                  end
                  S_RAT: begin
                     r_ff     <= fpu_res;
                     state_ff <= S_T1;
                  end
                  S_T1: begin
                     t_ff     <= fpu_res;
                     state_ff <= S_T2;
                  end
                  S_T2: begin
                     r_ff     <= fpu_res;
                     state_ff <= S_T3;
                  end
                  S_T3: begin
                     r_ff     <= fpu_res;
                     state_ff <= S_T4;
                  end
                  S_T4: begin
                     sumsq_ff <= fpu_res;
                     scl_ff   <= H_ONE;
                     state_ff <= S_SQRT;
                  end
                  S_SQRT: begin
                     t_ff     <= fpu_res;
                     state_ff <= S_FIN;
                  end
                  default: begin
                     res_ff    <= h_nan(fpu_res) ? H_QNAN : fpu_res;
                     small_ff  <= H_ZERO;
                     medium_ff <= H_ZERO;
                     big_ff    <= H_ZERO;
                     nbs_ff    <= 1'b1;
                     state_ff  <= S_OUT;
                  end
               endcase
            end
         end else begin
            case (state_ff)
               S_IDLE: begin
                  if (accept) begin
                     last_ff <= req_is_last;
                     t_ff    <= ax;
                     if (req_empty_vector) begin
                        res_ff    <= H_ZERO;
                        small_ff  <= H_ZERO;
                        medium_ff <= H_ZERO;
                        big_ff    <= H_ZERO;
                        nbs_ff    <= 1'b1;
                        state_ff  <= S_OUT;
                     end else if (h_gt(ax, T_BIG)) begin
                        cls_ff   <= CLS_BIG;
                        state_ff <= S_AMUL;
                     end else if (h_gt(T_SMALL, ax)) begin
                        cls_ff <= CLS_SMALL;
                        if (nbs_ff) state_ff <= S_AMUL;
                        else state_ff <= req_is_last ? S_CBEGIN : S_IDLE;
                     end else begin
                        cls_ff   <= CLS_MED;
                        state_ff <= S_ASQ;
                     end
                  end
               end
               S_CBEGIN: begin
                  if (h_gt(big_ff, H_ZERO)) begin
                     if (med_live) state_ff <= S_BM1;
                     else begin
                        sumsq_ff <= big_ff;
                        scl_ff   <= SCL_BIG;
                        state_ff <= S_SQRT;
                     end
                  end else if (h_gt(small_ff, H_ZERO)) begin
                     if (med_live) state_ff <= S_AM;
                     else begin
                        sumsq_ff <= small_ff;
                        scl_ff   <= SCL_SMALL;
                        state_ff <= S_SQRT;
                     end
                  end else begin
                     sumsq_ff <= medium_ff;
                     scl_ff   <= H_ONE;
                     state_ff <= S_SQRT;
                  end
               end
               default: begin
                  if (!rsp_valid_ff || !rsp_stall) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_norm_ff  <= res_ff;
                     state_ff     <= S_IDLE;
                  end
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_norm  = rsp_norm_ff;

endmodule

>>> rtl/hpen_fpu.sv
// Shared binary16 arithmetic unit: multiply, add, divide and square root,
// one rounding stage. Divide and square root retire one bit per cycle.
// Depends on hpen_pkg.
module hpen_fpu (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  hpen_pkg::fop_type op,
   input  logic [15:0]      opa,
   input  logic [15:0]      opb,
   input  logic [2:0]       mode,
   output logic             done,
   output logic [15:0]      result
);
   import hpen_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_ITER, F_ROUND} fstate_type;

   fstate_type        fst_ff;
   fop_type           op_ff;
   logic [4:0]        cnt_ff;
   logic [21:0]       rem_ff;
   logic [23:0]       q_ff;
   logic [37:0]       rad_ff;
   logic [10:0]       dv_ff;
   logic              raw_sign_ff;
   logic signed [8:0] raw_e_ff;
   logic [25:0]       raw_sig_ff;
   logic              raw_stk_ff;
   logic              spec_ff;
   logic [15:0]       spec_val_ff;
   logic              done_ff;
   logic [15:0]       result_ff;

   logic [2:0]        md;
   logic [4:0]        fa, fb;
   logic [10:0]       siga, sigb;
   logic signed [8:0] ea, eb;
   logic              sx;
   logic              spec;
   logic [15:0]       spec_val;
   logic [21:0]       mul_sig;
   logic              a_big;
   logic [10:0]       big_sig, sml_sig;
   logic signed [8:0] big_e, sml_e, dexp;
   logic [49:0]       sh_w;
   logic [24:0]       sj, bg;
   logic [25:0]       add_s;
   logic              add_sign, add_zero;
   logic [3:0]        sha, shb;
   logic [10:0]       na, nb;
   logic signed [8:0] ena, enb;
   logic [11:0]       sqm;
   logic signed [8:0] se2;
   logic [11:0]       rem12, diff12, rem_n12;
   logic              dge;
   logic [21:0]       cur, trial, rem_n;
   logic              sge;
   logic [23:0]       q_n;
   logic [4:0]        p;
   logic [25:0]       mnorm;
   logic signed [9:0] bexp;

   function automatic logic [3:0] norm11(input logic [10:0] x);
      logic [3:0] pos;
      pos = 4'd0;
      for (int i = 0; i < 11; i++) begin
         if (x[i]) pos = 4'(i);
      end
      return 4'd10 - pos;
   endfunction

   function automatic logic [15:0] fp_round(input logic sgn, input logic signed [9:0] be,
                                            input logic [25:0] m, input logic stk,
                                            input logic [2:0] rm);
      logic [15:0]       ovf;
      logic signed [9:0] diff;
      logic [4:0]        sh;
      logic [53:0]       w;
      logic              rb, rest, up;
      logic [11:0]       mv;
      logic [4:0]        ebits;
      logic [16:0]       bits;
      ovf = {sgn, ((rm == RM_RTZ) || (rm == RM_RDN && !sgn) || (rm == RM_RUP && sgn))
                  ? 15'h7BFF : 15'h7C00};
      diff = -10'sd14 - be;
      if (be >= -10'sd14) sh = 5'd15;
      else if (diff > 10'sd13) sh = 5'd28;
      else sh = 5'd15 + diff[4:0];
      w = {m, 28'd0} >> sh;
      rb = w[27];
      rest = (|w[26:0]) | stk;
      case (rm)
         RM_RTZ: up = 1'b0;
         RM_RDN: up = sgn && (rb || rest);
         RM_RUP: up = !sgn && (rb || rest);
         RM_RNA: up = rb;
         default: up = rb && (rest || w[28]);
      endcase
      mv = w[39:28] + {11'd0, up};
      ebits = (be >= -10'sd14) ? (be[4:0] + 5'd14) : 5'd0;
      bits = {2'b00, ebits, 10'd0} + {5'd0, mv};
      if (be > 10'sd15 || bits >= 17'h07C00) return ovf;
      return {sgn, bits[14:0]};
   endfunction

   assign md   = (mode <= RM_RNA) ? mode : RM_RNE;
   assign fa   = opa[14:10];
   assign fb   = opb[14:10];
   assign siga = {|fa, opa[9:0]};
   assign sigb = {|fb, opb[9:0]};
   assign ea   = $signed({4'd0, (fa == 5'd0) ? 5'd1 : fa}) - 9'sd25;
   assign eb   = $signed({4'd0, (fb == 5'd0) ? 5'd1 : fb}) - 9'sd25;
   assign sx   = opa[15] ^ opb[15];

   assign mul_sig = siga * sigb;

   always_comb begin
      a_big   = (ea >= eb);
      big_sig = a_big ? siga : sigb;
      sml_sig = a_big ? sigb : siga;
      big_e   = a_big ? ea : eb;
      sml_e   = a_big ? eb : ea;
      dexp    = big_e - sml_e;
      sh_w    = {sml_sig, 39'd0} >> dexp[4:0];
      sj      = sh_w[49:25] | {24'd0, |sh_w[24:0]};
      bg      = {big_sig, 14'd0};
      add_zero = 1'b0;
      if ((a_big ? opa[15] : opb[15]) == (a_big ? opb[15] : opa[15])) begin
         add_s    = {1'b0, bg} + {1'b0, sj};
         add_sign = opa[15];
      end else if (bg > sj) begin
         add_s    = {1'b0, bg - sj};
         add_sign = a_big ? opa[15] : opb[15];
      end else begin
         add_s    = {1'b0, sj - bg};
         add_sign = a_big ? opb[15] : opa[15];
         add_zero = (sj == bg);
      end
   end

   always_comb begin
      sha = norm11(siga);
      shb = norm11(sigb);
      na  = siga << sha;
      nb  = sigb << shb;
      ena = ea - $signed({5'd0, sha});
      enb = eb - $signed({5'd0, shb});
      sqm = ena[0] ? {na, 1'b0} : {1'b0, na};
      se2 = ena[0] ? ena - 9'sd1 : ena;
   end

   always_comb begin
      spec     = 1'b0;
      spec_val = H_QNAN;
      case (op)
         FOP_MUL: begin
            if (h_nan(opa) || h_nan(opb)) spec = 1'b1;
            else if (h_inf(opa) || h_inf(opb)) begin
               spec = 1'b1;
               if (!(h_zero(opa) || h_zero(opb))) spec_val = {sx, H_INF[14:0]};
            end else if (h_zero(opa) || h_zero(opb)) begin
               spec     = 1'b1;
               spec_val = {sx, 15'd0};
            end
         end
         FOP_ADD: begin
            if (h_nan(opa) || h_nan(opb)) spec = 1'b1;
            else if (h_inf(opa)) begin
               spec = 1'b1;
               if (!(h_inf(opb) && sx)) spec_val = opa;
            end else if (h_inf(opb)) begin
               spec     = 1'b1;
               spec_val = opb;
            end else if (h_zero(opa) && h_zero(opb)) begin
               spec     = 1'b1;
               spec_val = !sx ? opa : ((md == RM_RDN) ? 16'h8000 : H_ZERO);
            end else if (h_zero(opa)) begin
               spec     = 1'b1;
               spec_val = opb;
            end else if (h_zero(opb)) begin
               spec     = 1'b1;
               spec_val = opa;
            end else if (add_zero) begin
               spec     = 1'b1;
               spec_val = (md == RM_RDN) ? 16'h8000 : H_ZERO;
            end
         end
         FOP_DIV: begin
            if (h_nan(opa) || h_nan(opb)) spec = 1'b1;
            else if (h_inf(opa)) begin
               spec = 1'b1;
               if (!h_inf(opb)) spec_val = {sx, H_INF[14:0]};
            end else if (h_inf(opb)) begin
               spec     = 1'b1;
               spec_val = {sx, 15'd0};
            end else if (h_zero(opb)) begin
               spec = 1'b1;
               if (!h_zero(opa)) spec_val = {sx, H_INF[14:0]};
            end else if (h_zero(opa)) begin
               spec     = 1'b1;
               spec_val = {sx, 15'd0};
            end
         end
         default: begin
            if (h_nan(opa)) spec = 1'b1;
            else if (h_zero(opa)) begin
               spec     = 1'b1;
               spec_val = opa;
            end else if (opa[15]) spec = 1'b1;
            else if (h_inf(opa)) begin
               spec     = 1'b1;
               spec_val = opa;
            end
         end
      endcase
   end

   always_comb begin
      rem12   = rem_ff[11:0];
      dge     = rem12 >= {1'b0, dv_ff};
      diff12  = rem12 - {1'b0, dv_ff};
      rem_n12 = dge ? {diff12[10:0], 1'b0} : {rem12[10:0], 1'b0};
      cur     = {rem_ff[19:0], rad_ff[37:36]};
      trial   = {1'b0, q_ff[18:0], 2'b01};
      sge     = cur >= trial;
      rem_n   = sge ? cur - trial : cur;
      q_n     = {q_ff[22:0], (op_ff == FOP_DIV) ? dge : sge};
   end

   always_comb begin
      p = 5'd0;
      for (int i = 0; i < 26; i++) begin
         if (raw_sig_ff[i]) p = 5'(i);
      end
      mnorm = raw_sig_ff << (5'd25 - p);
      bexp  = 10'(raw_e_ff) + $signed({5'd0, p});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fst_ff  <= F_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (fst_ff)
            F_IDLE: begin
               if (start) begin
                  op_ff       <= op;
                  spec_ff     <= spec;
                  spec_val_ff <= spec_val;
                  raw_stk_ff  <= 1'b0;
                  q_ff        <= 24'd0;
                  case (op)
                     FOP_MUL: begin
                        raw_sign_ff <= sx;
                        raw_e_ff    <= ea + eb;
                        raw_sig_ff  <= {4'd0, mul_sig};
                        fst_ff      <= F_ROUND;
                     end
                     FOP_ADD: begin
                        raw_sign_ff <= add_sign;
                        raw_e_ff    <= big_e - 9'sd14;
                        raw_sig_ff  <= add_s;
                        fst_ff      <= F_ROUND;
                     end
                     FOP_DIV: begin
                        raw_sign_ff <= sx;
                        raw_e_ff    <= ena - enb - 9'sd23;
                        rem_ff      <= {11'd0, na};
                        dv_ff       <= nb;
                        cnt_ff      <= 5'd23;
                        fst_ff      <= spec ? F_ROUND : F_ITER;
                     end
                     default: begin
                        raw_sign_ff <= 1'b0;
                        raw_e_ff    <= (se2 - 9'sd26) >>> 1;
                        rem_ff      <= 22'd0;
                        rad_ff      <= {sqm, 26'd0};
                        cnt_ff      <= 5'd18;
                        fst_ff      <= spec ? F_ROUND : F_ITER;
                     end
                  endcase
               end
            end
            F_ITER: begin
               q_ff   <= q_n;
               rad_ff <= rad_ff << 2;
               rem_ff <= (op_ff == FOP_DIV) ? {10'd0, rem_n12} : rem_n;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  fst_ff <= F_ROUND;
                  if (op_ff == FOP_DIV) begin
                     raw_sig_ff <= {2'b00, q_n};
                     raw_stk_ff <= rem_n12 != 12'd0;
                  end else begin
                     raw_sig_ff <= {7'd0, q_n[18:0]};
                     raw_stk_ff <= rem_n != 22'd0;
                  end
               end
            end
            F_ROUND: begin
               result_ff <= spec_ff ? spec_val_ff
                          : fp_round(raw_sign_ff, bexp, mnorm, raw_stk_ff, md);
               done_ff   <= 1'b1;
               fst_ff    <= F_IDLE;
            end
            default: fst_ff <= F_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

>>> rtl/hpen_checker.sv
// Port-level checks for half_precision_euclidean_norm, attached by bind.
// Depends only on the top level's ports.
module hpen_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_norm
);

   a_known_handshake: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_stall, rsp_valid}))
      else $error("handshake output unknown");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_norm))
      else $error("stalled response dropped or changed");

   a_nan_canon: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_norm[14:10] == 5'h1F && rsp_norm[9:0] != 10'd0
      |-> rsp_norm == 16'h7E00)
      else $error("non-canonical NaN on response");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared while idle");

endmodule

bind half_precision_euclidean_norm hpen_checker u_hpen_checker (.*);

>>> bench/tb.sv
// Self-checking bench for half_precision_euclidean_norm: streams fp16 vectors,
// predicts each norm with a local binary16 model and checks every response.
// Depends on rtl/hpen_pkg.sv and rtl/half_precision_euclidean_norm.sv.
`timescale 1ns / 100ps

module tb;
   import hpen_pkg::*;

   typedef struct packed {
      logic [15:0] element;
      logic        is_last;
      logic        empty_vector;
   } elem_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_element = 16'd0;
   logic        req_is_last = 1'b0;
   logic        req_empty_vector = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_norm;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_wr_data = 3'd0;

   elem_req_type pending_reqs[$];
   logic [15:0] expected_norms[$];
   logic [2:0]  mode;
   logic [15:0] small_acc, medium_acc, big_acc;
   logic        no_big;
   int          errors = 0;
   int          norms_seen = 0;
   int          reqs_sent = 0;
   int          cycles = 0;
   bit          calm = 1'b0;
   bit          req_taken = 1'b0;

   half_precision_euclidean_norm dut (.*);

   always #10 clock = ~clock;

   // ---------------- binary16 arithmetic ----------------
   function automatic logic [2:0] eff_mode();
      return (mode <= RM_RNA) ? mode : RM_RNE;
   endfunction

   function automatic logic [15:0] ovf(input logic s);
      logic [2:0] m;
      m = eff_mode();
      if (m == RM_RTZ || (m == RM_RDN && !s) || (m == RM_RUP && s))
         return {s, 15'h7BFF};
      return {s, 15'h7C00};
   endfunction

   function automatic void unpack(input logic [15:0] x, output longint unsigned sig,
                                  output int e);
      sig = {53'd0, x[14:10] != 0, x[9:0]};
      e = ((x[14:10] != 0) ? int'(x[14:10]) : 1) - 25;
   endfunction

   function automatic logic [15:0] round16(input logic s, input int e,
                                           input longint unsigned sig, input bit sticky);
      int p, be, sh;
      longint unsigned m;
      bit rb, rest, up;
      logic [2:0] md;
      longint unsigned bits;
      md = eff_mode();
      p = 63;
      while (p > 0 && !sig[p]) p--;
      be = p + e;
      if (be > 15) return ovf(s);
      sh = (be >= -14) ? p - 10 : -24 - e;
      if (sh <= 0) begin
         m = sig << (-sh); rb = 0; rest = sticky;
      end else if (sh > 62) begin
         m = 0; rb = 0; rest = 1;
      end else begin
         m = sig >> sh;
         rb = sig[sh-1];
         rest = ((sig & ((64'd1 << (sh - 1)) - 1)) != 0) || sticky;
      end
      case (md)
         RM_RTZ: up = 0;
         RM_RDN: up = s && (rb || rest);
         RM_RUP: up = !s && (rb || rest);
         RM_RNA: up = rb;
         default: up = rb && (rest || m[0]);
      endcase
      m += up;
      bits = ((be >= -14) ? longint'(be + 14) << 10 : 0) + m;
      if (bits >= 64'h7C00) return ovf(s);
      return {s, bits[14:0]};
   endfunction

   function automatic logic [15:0] fmul(input logic [15:0] a, input logic [15:0] b);
      logic s;
      longint unsigned sa, sb;
      int ea, eb;
      s = a[15] ^ b[15];
      if (h_nan(a) || h_nan(b)) return H_QNAN;
      if (h_inf(a) || h_inf(b)) begin
         if (h_zero(a) || h_zero(b)) return H_QNAN;
         return {s, 15'h7C00};
      end
      if (h_zero(a) || h_zero(b)) return {s, 15'd0};
      unpack(a, sa, ea);
      unpack(b, sb, eb);
      return round16(s, ea + eb, sa * sb, 0);
   endfunction

   function automatic logic [15:0] fadd(input logic [15:0] a, input logic [15:0] b);
      longint unsigned ma, mb, sm;
      int ea, eb, e;
      logic s;
      logic [15:0] nz;
      nz = (eff_mode() == RM_RDN) ? 16'h8000 : H_ZERO;
      if (h_nan(a) || h_nan(b)) return H_QNAN;
      if (h_inf(a)) begin
         if (h_inf(b) && a[15] != b[15]) return H_QNAN;
         return a;
      end
      if (h_inf(b)) return b;
      if (h_zero(a) && h_zero(b)) return (a[15] == b[15]) ? a : nz;
      if (h_zero(a)) return b;
      if (h_zero(b)) return a;
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      e = (ea < eb) ? ea : eb;
      ma <<= (ea - e);
      mb <<= (eb - e);
      if (a[15] == b[15]) begin sm = ma + mb; s = a[15]; end
      else if (ma > mb) begin sm = ma - mb; s = a[15]; end
      else if (mb > ma) begin sm = mb - ma; s = b[15]; end
      else return nz;
      return round16(s, e, sm, 0);
   endfunction

   function automatic logic [15:0] fdiv(input logic [15:0] a, input logic [15:0] b);
      logic s;
      longint unsigned sa, sb, n;
      int ea, eb;
      s = a[15] ^ b[15];
      if (h_nan(a) || h_nan(b)) return H_QNAN;
      if (h_inf(a)) return h_inf(b) ? H_QNAN : {s, 15'h7C00};
      if (h_inf(b)) return {s, 15'd0};
      if (h_zero(b)) return h_zero(a) ? H_QNAN : {s, 15'h7C00};
      if (h_zero(a)) return {s, 15'd0};
      unpack(a, sa, ea);
      unpack(b, sb, eb);
      n = sa << 40;
      return round16(s, ea - eb - 40, n / sb, (n % sb) != 0);
   endfunction

   function automatic logic [15:0] fsqrt(input logic [15:0] a);
      longint unsigned sig, n, res, bitv;
      int e;
      if (h_nan(a)) return H_QNAN;
      if (h_zero(a)) return a;
      if (a[15]) return H_QNAN;
      if (h_inf(a)) return a;
      unpack(a, sig, e);
      if (e % 2 != 0) begin sig <<= 1; e -= 1; end
      n = sig << 40;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else res >>= 1;
         bitv >>= 2;
      end
      return round16(1'b0, (e - 40) / 2, res, n != 0);
   endfunction

   // ---------------- norm predictor ----------------
   function automatic void clear_sums();
      small_acc = H_ZERO; medium_acc = H_ZERO; big_acc = H_ZERO; no_big = 1'b1;
   endfunction

   function automatic void add_element(input logic [15:0] x);
      logic [15:0] ax, t;
      ax = {1'b0, x[14:0]};
      if (h_gt(ax, T_BIG)) begin
         t = fmul(ax, S_BIG);
         big_acc = fadd(big_acc, fmul(t, t));
         no_big = 1'b0;
      end else if (h_gt(T_SMALL, ax)) begin
         if (no_big) begin
            t = fmul(ax, S_SMALL);
            small_acc = fadd(small_acc, fmul(t, t));
         end
      end else medium_acc = fadd(medium_acc, fmul(ax, ax));
   endfunction

   function automatic logic [15:0] final_norm();
      logic [15:0] scl, sumsq, am, as, lo, hi, r, o;
      bit med_live;
      med_live = h_gt(medium_acc, H_ZERO) || h_nan(medium_acc);
      if (h_gt(big_acc, H_ZERO)) begin
         if (med_live) big_acc = fadd(big_acc, fmul(fmul(medium_acc, S_BIG), S_BIG));
         scl = fdiv(H_ONE, S_BIG);
         sumsq = big_acc;
      end else if (h_gt(small_acc, H_ZERO)) begin
         if (med_live) begin
            am = fsqrt(medium_acc);
            as = fdiv(fsqrt(small_acc), S_SMALL);
            lo = h_gt(as, am) ? am : as;
            hi = h_gt(as, am) ? as : am;
            r = fdiv(lo, hi);
            scl = H_ONE;
            sumsq = fmul(fmul(hi, hi), fadd(H_ONE, fmul(r, r)));
         end else begin
            scl = fdiv(H_ONE, S_SMALL);
            sumsq = small_acc;
         end
      end else begin
         scl = H_ONE;
         sumsq = medium_acc;
      end
      o = fmul(scl, fsqrt(sumsq));
      return h_nan(o) ? H_QNAN : o;
   endfunction

   function automatic void predict(input elem_req_type r);
      if (r.empty_vector) begin
         clear_sums();
         expected_norms.push_back(H_ZERO);
      end else begin
         add_element(r.element);
         if (r.is_last) begin
            expected_norms.push_back(final_norm());
            clear_sums();
         end
      end
   endfunction

   // ---------------- stimulus ----------------
   function automatic logic [15:0] rand_elem();
      case ($urandom_range(0, 9))
         0: return {1'($urandom_range(0, 1)), 5'd0, 10'($urandom)};
         1: return {1'($urandom_range(0, 1)), 5'($urandom_range(1, 7)), 10'($urandom)};
         2, 3: return {1'($urandom_range(0, 1)), 5'($urandom_range(8, 17)), 10'($urandom)};
         4, 5: return {1'($urandom_range(0, 1)), 5'($urandom_range(18, 30)), 10'($urandom)};
         6: return 16'($urandom);
         7: return {1'($urandom_range(0, 1)), 5'($urandom_range(8, 11)), 10'($urandom)};
         8: return {1'($urandom_range(0, 1)), 15'h7C00 | 15'($urandom_range(0, 1))};
         default: return {1'($urandom_range(0, 1)), 5'($urandom_range(20, 30)),
                          10'($urandom)};
      endcase
   endfunction

   task automatic push_vec(input int len);
      elem_req_type r;
      for (int i = 0; i < len; i++) begin
         r.element = rand_elem();
         r.is_last = (i == len - 1);
         r.empty_vector = ($urandom_range(0, 99) == 0);
         pending_reqs.push_back(r);
      end
   endtask

   task automatic push_req(input logic [15:0] e, input logic last, input logic empty);
      pending_reqs.push_back('{e, last, empty});
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_norms.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_mode(input logic [2:0] m);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------- driver ----------------
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
               {req_element, req_is_last, req_empty_vector} <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               req_element <= 16'($urandom);
               req_is_last <= 1'($urandom);
               req_empty_vector <= 1'($urandom);
            end
         end
         req_taken = 1'b0;
         rsp_stall <= !calm && ($urandom_range(0, 99) < 31);
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && !req_stall) begin
         predict('{req_element, req_is_last, req_empty_vector});
         reqs_sent++;
         req_taken = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         norms_seen <= norms_seen + 1;
         if (expected_norms.size() == 0) begin
            errors <= errors + 1;
            if (errors < 10) $display("unexpected norm %h", rsp_norm);
         end else if (expected_norms[0] !== rsp_norm) begin
            errors <= errors + 1;
            if (errors < 10)
               $display("norm: expected %h actual %h", expected_norms[0], rsp_norm);
            void'(expected_norms.pop_front());
         end else void'(expected_norms.pop_front());
      end
      if (cycles > 1500000) begin
         $display("half_precision_euclidean_norm: mismatch");
         $finish;
      end
   end

   initial begin
      logic [2:0] modes[6];
      mode = RM_RNE;
      clear_sums();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_req(16'h0000, 1'b1, 1'b0);
      push_req(16'h8000, 1'b0, 1'b0);
      push_req(16'h7BFF, 1'b0, 1'b0);
      push_req(16'hFBFF, 1'b1, 1'b0);
      push_req(16'h0001, 1'b0, 1'b0);
      push_req(16'h1FFF, 1'b0, 1'b0);
      push_req(16'h2000, 1'b1, 1'b0);
      push_req(16'h4800, 1'b0, 1'b0);
      push_req(16'h4801, 1'b0, 1'b0);
      push_req(16'h0001, 1'b1, 1'b0);
      push_req(16'h3C00, 1'b0, 1'b0);
      push_req(16'h7C00, 1'b0, 1'b0);
      push_req(16'h5555, 1'b1, 1'b1);
      push_req(16'h7E00, 1'b1, 1'b0);
      push_req(16'hFC00, 1'b0, 1'b0);
      push_req(16'h7D01, 1'b1, 1'b0);
      push_req(16'h03FF, 1'b0, 1'b0);
      push_req(16'hBC00, 1'b1, 1'b0);
      push_req(16'h0400, 1'b0, 1'b0);
      push_req(16'h4000, 1'b1, 1'b0);
      drain();

      modes = '{RM_RTZ, RM_RDN, RM_RUP, RM_RNA, 3'd7, RM_RNE};
      foreach (modes[k]) begin
         set_mode(modes[k]);
         mode = modes[k];
         calm = (k == 2);
         while (pending_reqs.size() < 66) push_vec($urandom_range(1, 6));
         drain();
      end
      for (int m = 5; m <= 6; m++) begin
         set_mode(3'(m));
         mode = 3'(m);
         push_vec(3);
         push_vec(1);
         drain();
      end
      calm = 1'b0;
      $display("covered %0d requests and %0d norms over all rounding modes",
               reqs_sent, norms_seen);
      if (errors == 0)
         $display("half_precision_euclidean_norm: match");
      else
         $display("half_precision_euclidean_norm: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
rtl/hpen_pkg.sv
rtl/hpen_fpu.sv
rtl/half_precision_euclidean_norm.sv
rtl/hpen_checker.sv
bench/tb.sv
